### src/otpq_pkg.sv
`timescale 1ns / 1ps
package otpq_pkg;

    localparam int COORD_BITS = 24;
    localparam int OUT_BITS   = 16;
    localparam int SCALE_BITS = 32;
    localparam int SCALE_FRAC = 24;
    localparam int EXTRA_FRAC = 3;
    localparam int DATA_BITS  = 32;
    localparam int ADDR_BITS  = 4;
    localparam int NUM_LANES  = 6;

    // points carried in eighths of a raw unit
    localparam int P8_BITS   = COORD_BITS + EXTRA_FRAC;
    localparam int DIFF_BITS = P8_BITS + 1;
    localparam int PROD_BITS = P8_BITS + SCALE_BITS;
    localparam int NORM_SHIFT = SCALE_FRAC + EXTRA_FRAC;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [P8_BITS-1:0]    t_p8;
    typedef logic        [OUT_BITS-1:0]   t_norm;
    typedef logic        [SCALE_BITS-1:0] t_scale;

    typedef enum logic [1:0] {
        FN_MOVE  = 2'd0,
        FN_LINE  = 2'd1,
        FN_CONIC = 2'd2,
        FN_CUBIC = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        REG_ORIGIN_X = 2'd0,
        REG_ORIGIN_Y = 2'd1,
        REG_SCALE_X  = 2'd2,
        REG_SCALE_Y  = 2'd3
    } t_reg;

    typedef struct packed {
        logic valid;
        logic last;
    } t_ctl;

endpackage

### src/otpq_cmd.sv
`timescale 1ns / 1ps
module otpq_cmd import otpq_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [1:0]   i_func,
    input  t_coord       i_ctrl1_x,
    input  t_coord       i_ctrl1_y,
    input  t_coord       i_ctrl2_x,
    input  t_coord       i_ctrl2_y,
    input  t_coord       i_to_x,
    input  t_coord       i_to_y,
    output t_ctl         o_ctl,
    output t_p8          o_pts [NUM_LANES]
);

    logic   r_cmd_v;
    logic   r_phase;
    t_func  r_func;
    t_coord r_c1x, r_c1y, r_c2x, r_c2y, r_tx, r_ty;
    t_coord r_px, r_py;
    t_coord r_last_x, r_last_y;
    t_ctl   r_ctl;
    t_p8    r_pts [NUM_LANES];
    t_p8    n_pts [NUM_LANES];

    logic take;
    logic issue_last;
    logic acc;

    t_p8 px, py, c1x, c1y, c2x, c2y, tx, ty;
    t_p8 s12x, s12y, mx, my, q0x, q0y, r1x, r1y, lcx, lcy;

    assign issue_last = (r_func != FN_CUBIC) || r_phase;
    assign take       = i_en && r_cmd_v;
    assign o_ready    = !r_cmd_v || (take && issue_last);
    assign acc        = i_valid && o_ready;

    assign px  = t_p8'(r_px);
    assign py  = t_p8'(r_py);
    assign c1x = t_p8'(r_c1x);
    assign c1y = t_p8'(r_c1y);
    assign c2x = t_p8'(r_c2x);
    assign c2y = t_p8'(r_c2y);
    assign tx  = t_p8'(r_tx);
    assign ty  = t_p8'(r_ty);

    // de casteljau at t = 1/2, all in eighths
    assign s12x = c1x + c2x;
    assign s12y = c1y + c2y;
    assign mx   = px + s12x + (s12x <<< 1) + tx;
    assign my   = py + s12y + (s12y <<< 1) + ty;
    assign q0x  = (px + c1x) <<< 2;
    assign q0y  = (py + c1y) <<< 2;
    assign r1x  = (c1x + (c2x <<< 1) + tx) <<< 1;
    assign r1y  = (c1y + (c2y <<< 1) + ty) <<< 1;
    assign lcx  = (px + tx) <<< 2;
    assign lcy  = (py + ty) <<< 2;

    always_comb begin
        n_pts[0] = px <<< 3;
        n_pts[1] = py <<< 3;
        n_pts[2] = c1x <<< 3;
        n_pts[3] = c1y <<< 3;
        n_pts[4] = tx <<< 3;
        n_pts[5] = ty <<< 3;
        unique case (r_func)
            FN_LINE: begin
                n_pts[2] = lcx;
                n_pts[3] = lcy;
            end
            FN_CUBIC: begin
                if (r_phase) begin
                    n_pts[0] = mx;
                    n_pts[1] = my;
                    n_pts[2] = r1x;
                    n_pts[3] = r1y;
                end else begin
                    n_pts[2] = q0x;
                    n_pts[3] = q0y;
                    n_pts[4] = mx;
                    n_pts[5] = my;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_v  <= 1'b0;
            r_phase  <= 1'b0;
            r_last_x <= '0;
            r_last_y <= '0;
            r_ctl    <= '0;
        end else begin
            if (take && !issue_last) begin
                r_phase <= 1'b1;
            end
            if (acc) begin
                r_cmd_v  <= 1'b1;
                r_phase  <= 1'b0;
                r_func   <= t_func'(i_func);
                r_c1x    <= i_ctrl1_x;
                r_c1y    <= i_ctrl1_y;
                r_c2x    <= i_ctrl2_x;
                r_c2y    <= i_ctrl2_y;
                r_tx     <= i_to_x;
                r_ty     <= i_to_y;
                r_px     <= r_last_x;
                r_py     <= r_last_y;
                r_last_x <= i_to_x;
                r_last_y <= i_to_y;
            end else if (take && issue_last) begin
                r_cmd_v <= 1'b0;
            end
            if (i_en) begin
                // a move leaves a bubble
                r_ctl.valid <= r_cmd_v && (r_func != FN_MOVE);
                r_ctl.last  <= issue_last;
                r_pts       <= n_pts;
            end
        end
    end

    assign o_ctl = r_ctl;
    assign o_pts = r_pts;

endmodule

### src/otpq_lane.sv
`timescale 1ns / 1ps
module otpq_lane import otpq_pkg::*; (
    input  logic   i_clk,
    input  logic   i_en,
    input  t_p8    i_p8,
    input  t_coord i_origin,
    input  t_scale i_scale,
    output t_norm  o_norm
);

    logic signed [DIFF_BITS-1:0] diff;
    logic [P8_BITS-1:0]   r_ud;
    logic [PROD_BITS-1:0] r_prod;
    t_norm                r_norm;

    assign diff = DIFF_BITS'(i_p8) - (DIFF_BITS'(i_origin) <<< EXTRA_FRAC);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // left of origin clamps to zero
            r_ud   <= (diff > 0) ? diff[P8_BITS-1:0] : '0;
            r_prod <= PROD_BITS'(r_ud) * PROD_BITS'(i_scale);
            if (|r_prod[PROD_BITS-1:NORM_SHIFT+OUT_BITS]) begin
                r_norm <= '1;
            end else begin
                r_norm <= r_prod[NORM_SHIFT+OUT_BITS-1:NORM_SHIFT];
            end
        end
    end

    assign o_norm = r_norm;

endmodule

### src/outline_to_packed_quadratics.sv
`timescale 1ns / 1ps
// command, point, difference, product and norm registers lie before the output
// throughput: one command per cycle for move, line and conic unless stalled; a
// cubic's two curves share the six normalize lanes, one curve a cycle
// a full output register stalls the whole pipe until it is taken
// reset (synchronous, active low) clears the pen to 0, origins to 0, scales to 1.0
module outline_to_packed_quadratics import otpq_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_func,
    input  t_coord               i_ctrl1_x,
    input  t_coord               i_ctrl1_y,
    input  t_coord               i_ctrl2_x,
    input  t_coord               i_ctrl2_y,
    input  t_coord               i_to_x,
    input  t_coord               i_to_y,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_norm                o_start_x,
    output t_norm                o_start_y,
    output t_norm                o_control_x,
    output t_norm                o_control_y,
    output t_norm                o_end_x,
    output t_norm                o_end_y,
    output logic                 o_last_of_run,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    t_coord r_origin_x, r_origin_y;
    t_scale r_scale_x, r_scale_y;
    t_ctl   r_ctl2, r_ctl3, r_ctl4;
    t_ctl   w_ctl1;
    t_p8    w_pts  [NUM_LANES];
    t_norm  w_norm [NUM_LANES];
    logic   en;
    logic   wr;
    t_reg   reg_sel;

    assign en      = !r_ctl4.valid || i_ready;
    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite;
    assign reg_sel = t_reg'(paddr[ADDR_BITS-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_scale_x  <= t_scale'(1) << SCALE_FRAC;
            r_scale_y  <= t_scale'(1) << SCALE_FRAC;
        end else if (wr) begin
            unique case (reg_sel)
                REG_ORIGIN_X: r_origin_x <= pwdata[COORD_BITS-1:0];
                REG_ORIGIN_Y: r_origin_y <= pwdata[COORD_BITS-1:0];
                REG_SCALE_X:  r_scale_x  <= pwdata[SCALE_BITS-1:0];
                REG_SCALE_Y:  r_scale_y  <= pwdata[SCALE_BITS-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_ORIGIN_X: prdata = DATA_BITS'(r_origin_x);
            REG_ORIGIN_Y: prdata = DATA_BITS'(r_origin_y);
            REG_SCALE_X:  prdata = DATA_BITS'(r_scale_x);
            REG_SCALE_Y:  prdata = DATA_BITS'(r_scale_y);
        endcase
    end

    otpq_cmd u_cmd (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_func    (i_func),
        .i_ctrl1_x (i_ctrl1_x),
        .i_ctrl1_y (i_ctrl1_y),
        .i_ctrl2_x (i_ctrl2_x),
        .i_ctrl2_y (i_ctrl2_y),
        .i_to_x    (i_to_x),
        .i_to_y    (i_to_y),
        .o_ctl     (w_ctl1),
        .o_pts     (w_pts)
    );

    // even lanes carry x, odd lanes y
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        otpq_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_p8     (w_pts[g]),
            .i_origin ((g % 2 == 0) ? r_origin_x : r_origin_y),
            .i_scale  ((g % 2 == 0) ? r_scale_x : r_scale_y),
            .o_norm   (w_norm[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2 <= '0;
            r_ctl3 <= '0;
            r_ctl4 <= '0;
        end else if (en) begin
            r_ctl2 <= w_ctl1;
            r_ctl3 <= r_ctl2;
            r_ctl4 <= r_ctl3;
        end
    end

    assign o_valid       = r_ctl4.valid;
    assign o_last_of_run = r_ctl4.last;
    assign o_start_x     = w_norm[0];
    assign o_start_y     = w_norm[1];
    assign o_control_x   = w_norm[2];
    assign o_control_y   = w_norm[3];
    assign o_end_x       = w_norm[4];
    assign o_end_y       = w_norm[5];

endmodule

### src/otpq_checker.sv
`timescale 1ns / 1ps
module otpq_checker import otpq_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [1:0]  i_func,
    input logic        o_valid,
    input logic        i_ready,
    input t_norm       o_start_x,
    input t_norm       o_end_y,
    input logic        o_last_of_run
);

    // a stalled curve holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_start_x) && $stable(o_end_y)
            && $stable(o_last_of_run))
        else $error("stalled output beat changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // first half of a cubic is followed at once by its last curve
    a_cubic_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_of_run |=> o_valid && o_last_of_run)
        else $error("cubic second curve missing");

    // a cubic keeps the front end busy while it is split in two
    a_cubic_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_func == FN_CUBIC) |=> !o_ready)
        else $error("input taken during cubic split");

endmodule

bind outline_to_packed_quadratics otpq_checker u_otpq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .i_func        (i_func),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_start_x     (o_start_x),
    .o_end_y       (o_end_y),
    .o_last_of_run (o_last_of_run)
);
